// ===== hdl/base64_strict_decoder_top_macros.svh =====
// assertion shorthands shared by the decoder modules
// each macro samples on the rising edge of clk and is off while rst is high
`ifndef BASE64_STRICT_DECODER_TOP_MACROS_SVH
`define BASE64_STRICT_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define B64SD_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define B64SD_ASSERT_NXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hdl/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sd_pkg
// Shared types, codes and helper functions of the strict base64 decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

  // internal sextet codes beyond the 0..63 data range
  localparam logic [6:0] CODE_PAD = 7'h7e;  // '=' (0xfe kept in 7 bits)
  localparam logic [6:0] CODE_BAD = 7'h7f;  // outside the alphabet

  // character constants
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CHAR = 2'd1;
  localparam logic [1:0] ERR_LEN  = 2'd2;

  // quad slots
  localparam logic [1:0] SLOT0 = 2'd0;
  localparam logic [1:0] SLOT1 = 2'd1;
  localparam logic [1:0] SLOT2 = 2'd2;
  localparam logic [1:0] SLOT3 = 2'd3;

  // result group made by one character: 1 to 3 results
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;    // number of results, 1..3
    logic            last;   // final result of the group ends the string
    logic [1:0]      err;    // nonzero: one empty item carrying this code
  } grp_t;

  // character to sextet, padding or bad code
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      d = ch - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      d = ch - 8'h61 + 8'd26;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30 + 8'd52;
    end else if (ch == CH_PLUS) begin
      d = 8'd62;
    end else if (ch == CH_SLASH) begin
      d = 8'd63;
    end else if (ch == CH_EQ) begin
      d = {1'b0, CODE_PAD};
    end else begin
      d = {1'b0, CODE_BAD};
    end
    return d[6:0];
  endfunction

  // bytes of one complete quad; a and b are data, c pad only if d pad
  function automatic grp_t emit_quad(input logic [6:0] a, input logic [6:0] b,
                                     input logic [6:0] c, input logic [6:0] d,
                                     input logic last);
    grp_t g;
    g.bytes[0] = {a[5:0], b[5:4]};
    g.bytes[1] = {b[3:0], c[5:2]};
    g.bytes[2] = {c[1:0], d[5:0]};
    if (c == CODE_PAD) begin
      g.cnt = 2'd1;
    end else if (d == CODE_PAD) begin
      g.cnt = 2'd2;
    end else begin
      g.cnt = 2'd3;
    end
    g.last = last;
    g.err  = ERR_NONE;
    return g;
  endfunction

endpackage

// ===== hdl/b64sd_dec.sv =====
// ----------------------------------------------------------------------------
// b64sd_dec
// Quad collector and strict checker: turns one registered character into
// at most one result group and keeps the per-string state.
// ----------------------------------------------------------------------------
module b64sd_dec import b64sd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic       url_mode,
  output logic       push,
  output grp_t       grp
);

  logic [2:0][6:0] held, held_next;
  logic [1:0]      pos, pos_next;
  logic [1:0]      err, err_next;
  logic [1:0]      err_chk;
  logic [7:0]      ch_map;
  logic [6:0]      code;
  logic            emit;
  grp_t            quad;
  logic            c_pad, d_pad;

  // url alphabet folding and sextet lookup
  always_comb begin
    ch_map = ch;
    if (url_mode && ch == CH_DASH) begin
      ch_map = CH_PLUS;
    end else if (url_mode && ch == CH_UNDER) begin
      ch_map = CH_SLASH;
    end
  end

  assign code  = sextet_of(ch_map);
  assign c_pad = (held[2] == CODE_PAD);
  assign d_pad = (code == CODE_PAD);

  // slot logic and checks
  always_comb begin
    held_next = held;
    pos_next  = pos;
    err_chk   = err;
    emit      = 1'b0;
    quad      = emit_quad(held[0], held[1], held[2], code, last);
    if (err == ERR_NONE) begin
      if (code == CODE_BAD) begin
        err_chk = ERR_CHAR;
      end else begin
        case (pos)
          SLOT0: begin
            if (d_pad) begin
              err_chk = ERR_CHAR;
            end else begin
              held_next[0] = code;
              pos_next     = SLOT1;
              if (last) err_chk = ERR_LEN;
            end
          end
          SLOT1: begin
            if (d_pad) begin
              err_chk = ERR_CHAR;
            end else begin
              held_next[1] = code;
              pos_next     = SLOT2;
              if (last) begin
                if (url_mode) begin
                  emit = 1'b1;
                  quad = emit_quad(held[0], code, CODE_PAD, CODE_PAD, 1'b1);
                end else begin
                  err_chk = ERR_LEN;
                end
              end
            end
          end
          SLOT2: begin
            held_next[2] = code;
            pos_next     = SLOT3;
            if (last) begin
              if (url_mode) begin
                emit = 1'b1;
                quad = emit_quad(held[0], held[1], code, CODE_PAD, 1'b1);
              end else begin
                err_chk = ERR_LEN;
              end
            end
          end
          default: begin
            if (c_pad && !d_pad) begin
              err_chk = ERR_CHAR;
            end else if ((c_pad || d_pad) && !last) begin
              err_chk = ERR_CHAR;
            end else begin
              emit = 1'b1;
            end
            pos_next = SLOT0;
          end
        endcase
      end
    end
    // string end clears everything
    err_next = err_chk;
    if (last) begin
      held_next = '0;
      pos_next  = SLOT0;
      err_next  = ERR_NONE;
    end
  end

  // result group: decoded bytes or the error end item
  always_comb begin
    grp  = quad;
    push = 1'b0;
    if (go) begin
      if (last && err_chk != ERR_NONE) begin
        push = 1'b1;
      end else begin
        push = emit;
      end
    end
    if (last && err_chk != ERR_NONE) begin
      grp.bytes = '0;
      grp.cnt   = 2'd1;
      grp.last  = 1'b1;
      grp.err   = err_chk;
    end
  end

  // per-string state
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      pos  <= SLOT0;
      err  <= ERR_NONE;
    end else if (go) begin
      held <= held_next;
      pos  <= pos_next;
      err  <= err_next;
    end
  end

endmodule

// ===== hdl/b64sd_gfifo.sv =====
// ----------------------------------------------------------------------------
// b64sd_gfifo
// Small queue of result groups between the decoder and the serializer.
// ----------------------------------------------------------------------------
`include "base64_strict_decoder_top_macros.svh"

module b64sd_gfifo import b64sd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  grp_t din,
  input  logic pop,
  output grp_t head,
  output logic empty,
  output logic full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `B64SD_ASSERT_IMP(a_no_push_full, push, !full, "group pushed into a full queue")
  `B64SD_ASSERT_IMP(a_no_pop_empty, pop, !empty, "group popped from an empty queue")
  `B64SD_ASSERT_NXT(a_count_up, push && !pop, count == $past(count) + CW'(1),
                    "fill count missed a push")

endmodule

// ===== hdl/b64sd_ser.sv =====
// ----------------------------------------------------------------------------
// b64sd_ser
// Walks the head group one result at a time into the output register.
// ----------------------------------------------------------------------------
`include "base64_strict_decoder_top_macros.svh"

module b64sd_ser import b64sd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  grp_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       end_of_string,
  output logic [1:0] error_code
);

  logic [1:0] idx;
  logic       load;
  logic       final_res;

  // output register is free when empty or its transfer completes now
  assign load      = !out_valid || !out_stall;
  assign final_res = (idx == head.cnt - 2'd1);
  assign pop       = load && !empty && final_res;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) idx <= final_res ? 2'd0 : idx + 2'd1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      data_byte     <= head.bytes[idx];
      byte_valid    <= (head.err == ERR_NONE);
      end_of_string <= head.last && final_res;
      error_code    <= final_res ? head.err : ERR_NONE;
    end
  end

  `B64SD_ASSERT_IMP(a_err_is_end, out_valid && error_code != ERR_NONE,
                    end_of_string && !byte_valid, "error result not an empty end item")
  `B64SD_ASSERT_IMP(a_idx_in_group, !empty, idx < head.cnt,
                    "result index beyond its group")

endmodule

// ===== hdl/base64_strict_decoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_strict_decoder_top
// Streaming strict base64 decoder with optional url alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_stall carries char_code and last_char, one
//   encoded character per transfer; last_char marks the end of a string.
//   output channel out_valid/out_stall carries data_byte, byte_valid,
//   end_of_string and error_code, one result per transfer. Every string
//   closes with one result that has end_of_string set: its last byte, or an
//   empty item with a nonzero error_code, after which its bytes are dropped.
//   config channel cfg_valid/cfg_ready/cfg_data writes url_mode; cfg_ready is
//   always high. Write it only while the decoder is idle.
// Timing:
//   a character is taken every cycle while the queue has room; a result
//   passes the input register, the group queue and the output register.
//   The output register delivers one result per cycle while out_stall is
//   low; a quad gives up to three, so a FIFO_DEPTH-group queue absorbs bursts.
// Reset clears the string state, the queue and url_mode. While the receiver
// stalls, the output holds, the queue fills and then in_stall rises.
// ----------------------------------------------------------------------------
module base64_strict_decoder_top import b64sd_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       end_of_string,
  output logic [1:0] error_code
);

  logic       url_mode;
  logic       inq_valid;
  logic [7:0] inq_char;
  logic       inq_last;
  logic       go;
  logic       accept;
  logic       push, pop, empty, full;
  grp_t       grp, head;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      url_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      url_mode <= cfg_data;
    end
  end

  // input register, drained whenever the queue has room
  assign go       = inq_valid && !full;
  assign in_stall = inq_valid && full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (accept) begin
      inq_valid <= 1'b1;
    end else if (go) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inq_char <= char_code;
      inq_last <= last_char;
    end
  end

  // decode one character into a result group
  b64sd_dec u_dec (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .ch       (inq_char),
    .last     (inq_last),
    .url_mode (url_mode),
    .push     (push),
    .grp      (grp)
  );

  // group queue
  b64sd_gfifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_gfifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (grp),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  // one result per output transfer
  b64sd_ser u_ser (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .end_of_string (end_of_string),
    .error_code    (error_code)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the strict base64 decoder. A directed table covers
// url and standard padding and length errors, standard bad characters, then
// random strings run in standard and url phases. Mostly they are well-formed,
// with some mutated, truncated and noise strings. Both channels idle at
// random, and the receiver holds off once for a long stretch. Every result
// transfer is checked field by field against a behavioral decoder.
// ----------------------------------------------------------------------------
module testbench;
  import b64sd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 285;
  localparam int HOLD_CYCLES  = 250;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       bv;
    logic       eos;
    logic [1:0] err;
  } result_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       url;
    logic       typed;
    result_t    res;
  } dir_row_t;

  // dut signals; the driven ones are known from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_code = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_string;
  logic [1:0] error_code;

  // hand-typed expectation that travels with the character
  logic       chk_typed = 1'b0;
  result_t    chk_result = '0;

  // decoder state of the predictor
  logic [6:0] quad_codes [3] = '{default: '0};
  logic [1:0] slot = SLOT0;
  logic [1:0] latched_err = ERR_NONE;
  logic       url_q = 1'b0;

  result_t    step_q[$];
  result_t    expected_q[$];
  dir_row_t   dir_rows[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  tx_quiet = 1'b0;
  bit  rx_quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  rx_wait = 0;
  int  rx_hold = 0;
  logic cur_mode = 1'b0;

  base64_strict_decoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_code     (char_code),
    .last_char     (last_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .end_of_string (end_of_string),
    .error_code    (error_code)
  );

  always #4 clk = ~clk;

  // character to sextet, with url symbols folded to standard ones
  function automatic logic [6:0] code_of(input logic [7:0] ch, input logic url);
    logic [7:0] c;
    c = ch;
    if (url && c == CH_DASH) c = CH_PLUS;
    else if (url && c == CH_UNDER) c = CH_SLASH;
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
    if (c == CH_PLUS) return 7'd62;
    if (c == CH_SLASH) return 7'd63;
    if (c == CH_EQ) return CODE_PAD;
    return CODE_BAD;
  endfunction

  // sextet to character; in url mode the two symbols come in either form
  function automatic logic [7:0] glyph(input logic [5:0] v, input logic url);
    if (v < 26) return "A" + v;
    if (v < 52) return "a" + v - 8'd26;
    if (v < 62) return "0" + v - 8'd52;
    if (v == 62) return (url && $urandom_range(0, 1)) ? CH_DASH : CH_PLUS;
    return (url && $urandom_range(0, 1)) ? CH_UNDER : CH_SLASH;
  endfunction

  function automatic result_t end_item(input logic [1:0] e);
    return '{8'h00, 1'b0, 1'b1, e};
  endfunction

  // bytes of one quad; c padded gives one byte, d padded two
  task automatic push_quad(input logic [6:0] a, input logic [6:0] b,
                           input logic [6:0] c, input logic [6:0] d,
                           input logic last);
    logic [23:0] bits;
    int n;
    bits = (24'(a[5:0]) << 18) | (24'(b[5:0]) << 12) | (24'(c[5:0]) << 6) | 24'(d[5:0]);
    n = (c == CODE_PAD) ? 1 : (d == CODE_PAD) ? 2 : 3;
    for (int k = 0; k < n; k++) begin
      step_q.push_back('{bits[23 - 8 * k -: 8], 1'b1, last && (k == n - 1), ERR_NONE});
    end
  endtask

  // one character through the predictor, results into step_q
  task automatic decode_char(input logic [7:0] ch, input logic last);
    logic [6:0] code;
    logic c_pad;
    logic d_pad;
    code = code_of(ch, url_q);
    if (latched_err == ERR_NONE) begin
      if (code == CODE_BAD) begin
        latched_err = ERR_CHAR;
      end else begin
        case (slot)
          SLOT0: begin
            if (code == CODE_PAD) begin
              latched_err = ERR_CHAR;
            end else begin
              quad_codes[0] = code;
              slot = SLOT1;
              if (last) latched_err = ERR_LEN;
            end
          end
          SLOT1: begin
            if (code == CODE_PAD) begin
              latched_err = ERR_CHAR;
            end else begin
              quad_codes[1] = code;
              slot = SLOT2;
              if (last && url_q) push_quad(quad_codes[0], code, CODE_PAD, CODE_PAD, 1'b1);
              else if (last) latched_err = ERR_LEN;
            end
          end
          SLOT2: begin
            quad_codes[2] = code;
            slot = SLOT3;
            if (last && url_q) push_quad(quad_codes[0], quad_codes[1], code, CODE_PAD, 1'b1);
            else if (last) latched_err = ERR_LEN;
          end
          default: begin
            c_pad = (quad_codes[2] == CODE_PAD);
            d_pad = (code == CODE_PAD);
            // pad then data, or padding before the end of the string
            if (c_pad && !d_pad) latched_err = ERR_CHAR;
            else if ((c_pad || d_pad) && !last) latched_err = ERR_CHAR;
            else push_quad(quad_codes[0], quad_codes[1], quad_codes[2], code, last);
            slot = SLOT0;
          end
        endcase
      end
    end
    // string end: report the first error, then start clean
    if (last) begin
      if (latched_err != ERR_NONE) step_q.push_back(end_item(latched_err));
      quad_codes = '{default: '0};
      slot = SLOT0;
      latched_err = ERR_NONE;
    end
  endtask

  task automatic report(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
               cycle_count, what, want, got);
  endtask

  // track config, input and output transfers
  always @(posedge clk) begin : track_b
    result_t want;
    if (!rst && cfg_valid && cfg_ready) url_q = cfg_data;
    if (!rst && in_valid && !in_stall) begin
      step_q.delete();
      decode_char(char_code, last_char);
      if (chk_typed) expected_q.push_back(chk_result);
      else foreach (step_q[k]) expected_q.push_back(step_q[k]);
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result, data_byte", 0, data_byte);
      end else begin
        want = expected_q.pop_front();
        if (data_byte !== want.data) report("data_byte", want.data, data_byte);
        if (byte_valid !== want.bv) report("byte_valid", want.bv, byte_valid);
        if (end_of_string !== want.eos) report("end_of_string", want.eos, end_of_string);
        if (error_code !== want.err) report("error_code", want.err, error_code);
      end
    end
  end

  // receiver: random wait per result, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) rx_wait = rx_quiet ? 0 : $urandom_range(0, 13);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // one character transfer, after a random gap
  task automatic send_char(input logic [7:0] ch, input logic last,
                           input logic typed, input result_t res);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    char_code  <= ch;
    last_char  <= last;
    chk_typed  <= typed;
    chk_result <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait until every pending result has been seen and the pipe is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  task automatic add_row(input logic [7:0] ch, input logic last, input logic url,
                         input logic typed, input result_t res);
    dir_rows.push_back('{ch, last, url, typed, res});
  endtask

  // stimulus
  initial begin
    logic [7:0] enc[$];
    logic [7:0] mut;
    int kind;
    int nq;
    int tail;
    int len;
    int drop;
    int sent;
    int strings;

    // standard alphabet: extremes, bad characters, padding and length errors
    add_row(8'h00, 1'b1, 1'b0, 1'b1, end_item(ERR_CHAR));
    add_row(8'hff, 1'b1, 1'b0, 1'b1, end_item(ERR_CHAR));
    add_row("A",   1'b1, 1'b0, 1'b1, end_item(ERR_LEN));
    add_row("T",   1'b0, 1'b0, 1'b0, '0);
    add_row("W",   1'b0, 1'b0, 1'b0, '0);
    add_row("F",   1'b0, 1'b0, 1'b0, '0);
    add_row("u",   1'b0, 1'b0, 1'b0, '0);
    // padding in the first slot, after bytes already went out
    add_row(CH_EQ, 1'b1, 1'b0, 1'b1, end_item(ERR_CHAR));
    // padding in the second slot, later characters ignored
    add_row("/",   1'b0, 1'b0, 1'b0, '0);
    add_row(CH_EQ, 1'b0, 1'b0, 1'b0, '0);
    add_row("x",   1'b1, 1'b0, 1'b1, end_item(ERR_CHAR));
    // pad followed by data
    add_row("Q",   1'b0, 1'b0, 1'b0, '0);
    add_row("U",   1'b0, 1'b0, 1'b0, '0);
    add_row(CH_EQ, 1'b0, 1'b0, 1'b0, '0);
    add_row("/",   1'b1, 1'b0, 1'b1, end_item(ERR_CHAR));
    // url alphabet: unpadded tail of three
    add_row(CH_DASH,  1'b0, 1'b1, 1'b0, '0);
    add_row(CH_UNDER, 1'b0, 1'b1, 1'b0, '0);
    add_row("z",      1'b1, 1'b1, 1'b0, '0);
    // padded quad that does not end the string
    add_row("/",   1'b0, 1'b1, 1'b0, '0);
    add_row("/",   1'b0, 1'b1, 1'b0, '0);
    add_row(CH_EQ, 1'b0, 1'b1, 1'b0, '0);
    add_row(CH_EQ, 1'b0, 1'b1, 1'b0, '0);
    add_row("9",   1'b1, 1'b1, 1'b1, end_item(ERR_CHAR));
    // explicit padding still accepted in url mode
    add_row("Q",   1'b0, 1'b1, 1'b0, '0);
    add_row("Q",   1'b0, 1'b1, 1'b0, '0);
    add_row(CH_EQ, 1'b0, 1'b1, 1'b0, '0);
    add_row(CH_EQ, 1'b1, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, ERR_NONE});
    // single character tail in url mode
    add_row("z",   1'b1, 1'b1, 1'b1, end_item(ERR_LEN));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].url != cur_mode) begin
        wait_idle();
        write_mode(dir_rows[i].url);
      end
      send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases, alternating the alphabet
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_mode(ph[0]);
      strings = 0;
      // long receiver hold while the sender keeps going
      if (ph == 2) hold_req = 1'b1;
      while (sent < (ph + 1) * RANDOM_ITEMS / 4) begin
        kind = $urandom_range(0, 9);
        enc.delete();
        if (kind == 9) begin
          // noise
          len = $urandom_range(1, 8);
          repeat (len) begin
            if ($urandom_range(0, 1)) enc.push_back(glyph(6'($urandom_range(0, 63)), cur_mode));
            else enc.push_back(8'($urandom_range(0, 255)));
          end
        end else begin
          nq = $urandom_range(0, 3);
          tail = $urandom_range(0, 3);
          if (nq == 0 && tail == 0) tail = 1;
          repeat (nq * 4) enc.push_back(glyph(6'($urandom_range(0, 63)), cur_mode));
          case (tail)
            1: begin
              repeat (2) enc.push_back(glyph(6'($urandom_range(0, 63)), cur_mode));
              enc.push_back(CH_EQ);
              enc.push_back(CH_EQ);
            end
            2: begin
              repeat (3) enc.push_back(glyph(6'($urandom_range(0, 63)), cur_mode));
              enc.push_back(CH_EQ);
            end
            3: begin
              repeat ($urandom_range(2, 3))
                enc.push_back(glyph(6'($urandom_range(0, 63)), cur_mode));
            end
            default: ;
          endcase
          // broken forms: one character replaced, or the end cut off
          if (kind == 7) begin
            case ($urandom_range(0, 3))
              0: mut = 8'($urandom_range(0, 255));
              1: mut = CH_EQ;
              2: mut = CH_DASH;
              default: mut = CH_UNDER;
            endcase
            enc[$urandom_range(0, enc.size() - 1)] = mut;
          end else if (kind == 8) begin
            drop = $urandom_range(1, enc.size() - 1);
            repeat (drop) void'(enc.pop_back());
          end
        end
        tx_quiet = (ph == 2 && strings < 8) || ($urandom_range(0, 4) == 0);
        rx_quiet = ($urandom_range(0, 4) == 0);
        foreach (enc[i]) send_char(enc[i], i == enc.size() - 1, 1'b0, '0);
        sent += enc.size();
        strings++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
